[hw/rtl/gsa_pkg.sv]
// Shared constants, codes and types of the generational slot allocator.
`default_nettype none
package gsa_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int GEN_W      = 32;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int STRIDE_W   = 13;
    localparam int SIZE_W     = 32;
    localparam int OFFSET_W   = 23;
    localparam int STATUS_W   = 3;
    localparam int PROD_W     = SLOT_W + STRIDE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - (STATUS_W + SLOT_W + GEN_W + OFFSET_W);
    localparam int IN_PAD_W   = IN_DATA_W - (SIZE_W + 1 + SLOT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_ARENA_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_FIRST  = 2'd3;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd64;
    localparam logic [CNT_W-1:0]    COUNT_RESET  = CNT_W'(MAX_SLOTS);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK            = 3'd0,
        STATUS_UNINIT        = 3'd1,
        STATUS_TOO_LARGE     = 3'd2,
        STATUS_FULL          = 3'd3,
        STATUS_FREE_IGNORED  = 3'd4,
        STATUS_FREE_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PATH_FAIL,
        PATH_RECYCLE,
        PATH_FRESH,
        PATH_FREE
    } path_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_POP,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic clear;
        logic latch;
        logic decide;
        logic pop;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic  clr_last;
        path_t path;
        logic  out_free;
    } stat_t;

endpackage
`default_nettype wire

[hw/rtl/gsa_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hw/rtl/gsa_ctrl.sv]
// Sequencer taking requests via decide, then pop and update as due.
`default_nettype none
module gsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire gsa_pkg::stat_t  stat,
    output gsa_pkg::cmd_t        cmd
);

    gsa_pkg::state_t state_reg;
    gsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            gsa_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = gsa_pkg::S_DECIDE;
                end
            end
            gsa_pkg::S_DECIDE:
            begin
                case (stat.path)
                    gsa_pkg::PATH_FAIL:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.decide = 1'b1;
                            state_next = gsa_pkg::S_IDLE;
                        end
                    end
                    gsa_pkg::PATH_RECYCLE:
                    begin
                        cmd.decide = 1'b1;
                        state_next = gsa_pkg::S_POP;
                    end
                    default:
                    begin
                        cmd.decide = 1'b1;
                        state_next = gsa_pkg::S_UPDATE;
                    end
                endcase
            end
            gsa_pkg::S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = gsa_pkg::S_UPDATE;
            end
            gsa_pkg::S_UPDATE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = gsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/gsa_datapath.sv]
// Configuration, request registers, counters, generation table and recycle stack.
`default_nettype none
module gsa_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [gsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [gsa_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,
    input  wire gsa_pkg::cmd_t                     cmd,
    output gsa_pkg::stat_t                         stat,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [gsa_pkg::OUT_DATA_W-1:0]         m_tdata
);

    localparam int SLOT_W   = gsa_pkg::SLOT_W;
    localparam int CNT_W    = gsa_pkg::CNT_W;
    localparam int GEN_W    = gsa_pkg::GEN_W;
    localparam int STRIDE_W = gsa_pkg::STRIDE_W;
    localparam int SIZE_W   = gsa_pkg::SIZE_W;

    logic                     enabled_reg;
    logic [STRIDE_W-1:0]      stride_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     reserve_reg;

    logic                     kind_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic                     present_reg;
    logic [SLOT_W-1:0]        number_reg;

    logic [CNT_W-1:0]         depth_reg;
    logic [CNT_W-1:0]         fresh_reg;
    logic [SLOT_W-1:0]        clr_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic                     free_reg;
    logic                     ovf_reg;
    logic                     m_tvalid_reg;
    logic [gsa_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [CNT_W-1:0]         count_eff;
    logic                     arena_ok;
    logic [CNT_W-1:0]         cand;
    logic [CNT_W-1:0]         depth_m1;
    logic                     stack_full;
    gsa_pkg::path_t           path;
    gsa_pkg::status_t         fail_status;
    gsa_pkg::status_t         done_status;

    logic                     stack_we;
    logic [SLOT_W-1:0]        stack_rdata;
    logic                     gen_we;
    logic [SLOT_W-1:0]        gen_waddr;
    logic [GEN_W-1:0]         gen_wdata;
    logic [SLOT_W-1:0]        gen_raddr;
    logic [GEN_W-1:0]         gen_rdata;
    logic [GEN_W-1:0]         gen_inc;
    logic [gsa_pkg::PROD_W-1:0] prod;
    logic                     out_load;

    assign count_eff  = (count_reg > CNT_W'(gsa_pkg::MAX_SLOTS))
                        ? CNT_W'(gsa_pkg::MAX_SLOTS) : count_reg;
    assign arena_ok   = enabled_reg && (stride_reg != '0);
    assign cand       = (reserve_reg && (fresh_reg == '0)) ? CNT_W'(1) : fresh_reg;
    assign depth_m1   = depth_reg - CNT_W'(1);
    assign stack_full = depth_reg >= CNT_W'(gsa_pkg::MAX_SLOTS);

    always_comb
    begin
        path        = gsa_pkg::PATH_FAIL;
        fail_status = gsa_pkg::STATUS_FREE_IGNORED;
        if (!kind_reg)
        begin
            if (!arena_ok)
            begin
                fail_status = gsa_pkg::STATUS_UNINIT;
            end
            else if (size_reg > SIZE_W'(stride_reg))
            begin
                fail_status = gsa_pkg::STATUS_TOO_LARGE;
            end
            else if (depth_reg != '0)
            begin
                path = gsa_pkg::PATH_RECYCLE;
            end
            else if (cand >= count_eff)
            begin
                fail_status = gsa_pkg::STATUS_FULL;
            end
            else
            begin
                path = gsa_pkg::PATH_FRESH;
            end
        end
        else if (arena_ok && present_reg && (CNT_W'(number_reg) < count_eff))
        begin
            path = gsa_pkg::PATH_FREE;
        end
    end

    assign stat.clr_last = clr_reg == SLOT_W'(gsa_pkg::MAX_SLOTS - 1);
    assign stat.path     = path;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign stack_we = cmd.decide && (path == gsa_pkg::PATH_FREE) && !stack_full;

    gsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (gsa_pkg::MAX_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (depth_reg[SLOT_W-1:0]),
        .wdata (number_reg),
        .raddr (depth_m1[SLOT_W-1:0]),
        .rdata (stack_rdata)
    );

    assign gen_inc   = gen_rdata + GEN_W'(1);
    assign gen_we    = cmd.clear || cmd.finish;
    assign gen_waddr = cmd.clear ? clr_reg : slot_reg;
    assign gen_wdata = cmd.clear ? GEN_W'(1) : gen_inc;

    always_comb
    begin
        if (cmd.decide)
        begin
            gen_raddr = (path == gsa_pkg::PATH_FREE) ? number_reg : cand[SLOT_W-1:0];
        end
        else if (cmd.pop)
        begin
            gen_raddr = stack_rdata;
        end
        else
        begin
            gen_raddr = slot_reg;
        end
    end

    gsa_ram #(
        .WIDTH (GEN_W),
        .DEPTH (gsa_pkg::MAX_SLOTS)
    ) u_gen (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rdata)
    );

    assign prod        = gsa_pkg::PROD_W'(slot_reg) * gsa_pkg::PROD_W'(stride_reg);
    assign done_status = (free_reg && ovf_reg) ? gsa_pkg::STATUS_FREE_OVERFLOW
                                                : gsa_pkg::STATUS_OK;
    assign out_load    = (cmd.decide && (path == gsa_pkg::PATH_FAIL)) || cmd.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            stride_reg   <= gsa_pkg::STRIDE_RESET;
            count_reg    <= gsa_pkg::COUNT_RESET;
            reserve_reg  <= 1'b0;
            depth_reg    <= '0;
            fresh_reg    <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gsa_pkg::CFG_ARENA_ENABLED: enabled_reg <= cfg_data[0];
                    gsa_pkg::CFG_SLOT_STRIDE:   stride_reg  <= cfg_data[STRIDE_W-1:0];
                    gsa_pkg::CFG_SLOT_COUNT:    count_reg   <= cfg_data[CNT_W-1:0];
                    gsa_pkg::CFG_RESERVE_FIRST: reserve_reg <= cfg_data[0];
                    default:                    reserve_reg <= reserve_reg;
                endcase
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.decide)
            begin
                case (path)
                    gsa_pkg::PATH_RECYCLE: depth_reg <= depth_m1;
                    gsa_pkg::PATH_FRESH:   fresh_reg <= cand + CNT_W'(1);
                    gsa_pkg::PATH_FREE:
                    begin
                        if (!stack_full)
                        begin
                            depth_reg <= depth_reg + CNT_W'(1);
                        end
                    end
                    default:               depth_reg <= depth_reg;
                endcase
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg    <= s_tuser;
            size_reg    <= s_tdata[SIZE_W-1:0];
            present_reg <= s_tdata[SIZE_W];
            number_reg  <= s_tdata[SIZE_W+SLOT_W:SIZE_W+1];
        end
        if (cmd.decide)
        begin
            free_reg <= path == gsa_pkg::PATH_FREE;
            ovf_reg  <= stack_full;
            slot_reg <= (path == gsa_pkg::PATH_FREE) ? number_reg : cand[SLOT_W-1:0];
        end
        if (cmd.pop)
        begin
            slot_reg <= stack_rdata;
        end
        if (cmd.decide && (path == gsa_pkg::PATH_FAIL))
        begin
            m_tdata_reg <= {gsa_pkg::OUT_PAD_W'(0), gsa_pkg::OFFSET_W'(0), GEN_W'(0),
                            SLOT_W'(0), fail_status};
        end
        else if (cmd.finish)
        begin
            m_tdata_reg <= {gsa_pkg::OUT_PAD_W'(0),
                            free_reg ? gsa_pkg::OFFSET_W'(0) : prod[gsa_pkg::OFFSET_W-1:0],
                            free_reg ? GEN_W'(0) : gen_inc,
                            free_reg ? SLOT_W'(0) : slot_reg,
                            done_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[hw/rtl/generational_slot_allocator_unit.sv]
// Top level of the generational slot allocator for one fixed-stride arena.
//
// After reset the block writes generation 1 into every entry of the
// generation table and takes no item in that time; configuration writes are
// taken throughout. Each item then walks through one register stage and the
// registered reads of the generation table and the recycle stack: a rejected
// request is registered in the decide state, a fresh allocate or a free in
// the update state, and an allocate from the recycle stack passes the pop state
// before update (the stack read before the generation read); update, and decide
// for a rejected request, wait while the output holds an untaken result. The next
// item is accepted the cycle after the result is registered, so no item is taken
// while one is in flight. Write configuration only while no request is in flight.
`default_nettype none
module generational_slot_allocator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [gsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // request_size[31:0], slot_present[32], slot_number[42:33], zero fill
    input  wire logic [gsa_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[2:0], granted_slot[12:3], granted_generation[44:13],
    // byte_offset[67:45], zero fill
    output logic [gsa_pkg::OUT_DATA_W-1:0]         m_tdata
);

    gsa_pkg::cmd_t  cmd;
    gsa_pkg::stat_t stat;

    gsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gsa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

[tb/generational_slot_allocator_unit_tb.sv]
// Self-checking testbench of the generational slot allocator: directed rows, then random traffic.
module generational_slot_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gsa_pkg::*;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic              present;
        logic [SLOT_W-1:0] number;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot;
        logic [GEN_W-1:0]    gen;
        logic [OFFSET_W-1:0] offset;
    } outcome_t;

    typedef struct packed {
        row_kind_t             what;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        request_t              req;
        logic                  typed;
        outcome_t              want;
    } script_row_t;

    localparam request_t NO_REQ      = '{KIND_ALLOC, 32'd0, 1'b0, 10'd0};
    localparam outcome_t O_DONE      = '{STATUS_OK, 10'd0, 32'd0, 23'd0};
    localparam outcome_t O_UNINIT    = '{STATUS_UNINIT, 10'd0, 32'd0, 23'd0};
    localparam outcome_t O_TOO_LARGE = '{STATUS_TOO_LARGE, 10'd0, 32'd0, 23'd0};
    localparam outcome_t O_FULL      = '{STATUS_FULL, 10'd0, 32'd0, 23'd0};
    localparam outcome_t O_IGNORED   = '{STATUS_FREE_IGNORED, 10'd0, 32'd0, 23'd0};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // shadow of the allocator
    logic                 arena_on;
    logic [STRIDE_W-1:0]  stride;
    logic [CNT_W-1:0]     count_reg;
    logic                 reserve0;
    logic [GEN_W-1:0]     gen_tbl [MAX_SLOTS];
    logic [SLOT_W-1:0]    recycle [MAX_SLOTS];
    int unsigned          recycle_top;
    int unsigned          next_fresh;

    outcome_t          outcomes_due [$];
    logic [SLOT_W-1:0] live_slots [$];
    int                mismatches   = 0;
    int                results_seen = 0;
    logic              sender_steady = 1'b0;

    script_row_t plan [28] = '{
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd0, 1'b0, 10'd0}, 1'b1, O_UNINIT},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd5}, 1'b1, O_IGNORED},
        '{ROW_CFG, CFG_RESERVE_FIRST, 13'd1, NO_REQ, 1'b0, O_DONE},
        '{ROW_CFG, CFG_ARENA_ENABLED, 13'd1, NO_REQ, 1'b0, O_DONE},
        '{ROW_CFG, CFG_SLOT_STRIDE, 13'd0, NO_REQ, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd0, 1'b0, 10'd0}, 1'b1, O_UNINIT},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd3}, 1'b1, O_IGNORED},
        '{ROW_CFG, CFG_SLOT_STRIDE, 13'd4096, NO_REQ, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd4097, 1'b0, 10'd0}, 1'b1,
            O_TOO_LARGE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 10'd1023}, 1'b1,
            O_TOO_LARGE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd4096, 1'b0, 10'd0}, 1'b1,
            '{STATUS_OK, 10'd1, 32'd2, 23'd4096}},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd0, 1'b0, 10'd0}, 1'b1,
            '{STATUS_OK, 10'd2, 32'd2, 23'd8192}},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b0, 10'd2}, 1'b1, O_IGNORED},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd1023}, 1'b1, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd0}, 1'b1, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd17, 1'b0, 10'd0}, 1'b0, O_DONE},
        '{ROW_CFG, CFG_SLOT_COUNT, 13'd2, NO_REQ, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd100, 1'b0, 10'd0}, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd0, 1'b0, 10'd0}, 1'b1, O_FULL},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd2}, 1'b1, O_IGNORED},
        '{ROW_CFG, CFG_SLOT_COUNT, 13'd0, NO_REQ, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd0, 1'b0, 10'd0}, 1'b1, O_FULL},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd0}, 1'b1, O_IGNORED},
        '{ROW_CFG, CFG_SLOT_COUNT, 13'h1FFF, NO_REQ, 1'b0, O_DONE},
        '{ROW_CFG, CFG_RESERVE_FIRST, 13'd0, NO_REQ, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd1023}, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_ALLOC, 32'd4096, 1'b0, 10'd0}, 1'b0, O_DONE},
        '{ROW_REQ, CFG_ARENA_ENABLED, 13'd0, '{KIND_FREE, 32'd0, 1'b1, 10'd1022}, 1'b0, O_DONE}
    };

    generational_slot_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    function automatic int unsigned usable_slots();
        return (count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg);
    endfunction

    function automatic outcome_t compute_outcome(request_t req);
        outcome_t    o;
        int unsigned lim;
        int unsigned cand;
        logic        ready;
        lim   = usable_slots();
        ready = arena_on && (stride != '0);
        o     = O_DONE;
        if (req.kind == KIND_ALLOC)
        begin
            if (!ready)
                o.status = STATUS_UNINIT;
            else if (req.size > stride)
                o.status = STATUS_TOO_LARGE;
            else if (recycle_top > 0)
            begin
                recycle_top--;
                o.slot = recycle[recycle_top];
            end
            else
            begin
                cand = next_fresh;
                if (reserve0 && cand == 0)
                    cand = 1;
                if (cand >= lim)
                    o.status = STATUS_FULL;
                else
                begin
                    o.slot     = SLOT_W'(cand);
                    next_fresh = cand + 1;
                end
            end
            if (o.status == STATUS_OK)
            begin
                gen_tbl[o.slot] = gen_tbl[o.slot] + 1'b1;
                o.gen    = gen_tbl[o.slot];
                o.offset = OFFSET_W'(32'(o.slot) * 32'(stride));
            end
        end
        else
        begin
            if (!ready || !req.present || req.number >= lim)
                o.status = STATUS_FREE_IGNORED;
            else
            begin
                gen_tbl[req.number] = gen_tbl[req.number] + 1'b1;
                if (recycle_top >= MAX_SLOTS)
                    o.status = STATUS_FREE_OVERFLOW;
                else
                begin
                    recycle[recycle_top] = req.number;
                    recycle_top++;
                end
            end
        end
        return o;
    endfunction

    task automatic put_item(input request_t req, input logic typed, input outcome_t want);
        outcome_t got;
        while (!sender_steady && $urandom_range(99) < 28)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {{IN_PAD_W{1'b0}}, req.number, req.present, req.size};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        got = compute_outcome(req);
        if (req.kind == KIND_ALLOC && got.status == STATUS_OK)
            live_slots.insert(live_slots.size(), got.slot);
        outcomes_due.insert(outcomes_due.size(), typed ? want : got);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ARENA_ENABLED: arena_on  = val[0];
            CFG_SLOT_STRIDE:   stride    = val;
            CFG_SLOT_COUNT:    count_reg = val[CNT_W-1:0];
            CFG_RESERVE_FIRST: reserve0  = val[0];
            default: ;
        endcase
    endtask

    // frees, often of live handles, and mostly fitting allocates, with some junk mixed in
    task automatic run_mix(input int n, input int alloc_pct);
        request_t    req;
        int unsigned pick;
        int unsigned lim;
        for (int i = 0; i < n; i++)
        begin
            lim          = usable_slots();
            req.kind     = ($urandom_range(99) < alloc_pct) ? KIND_ALLOC : KIND_FREE;
            pick         = $urandom_range(19);
            req.size     = (pick == 0) ? $urandom() :
                           (pick == 1) ? 32'(stride) + 32'd1 : $urandom_range(32'(stride), 0);
            req.present  = ($urandom_range(19) != 0);
            req.number   = SLOT_W'($urandom());
            if (req.kind == KIND_FREE && live_slots.size() != 0 && $urandom_range(3) != 0)
            begin
                pick       = $urandom_range(live_slots.size() - 1);
                req.number = live_slots[pick];
                live_slots.delete(pick);
            end
            else if (lim != 0 && $urandom_range(1) == 0)
                req.number = SLOT_W'($urandom_range(lim - 1));
            put_item(req, 1'b0, O_DONE);
        end
    endtask

    // push the recycle stack to its top, then keep freeing past it
    task automatic fill_recycle_stack(input int spill);
        request_t req;
        int       extra;
        extra = 0;
        while (extra < spill)
        begin
            req.kind    = ($urandom_range(99) < 2) ? KIND_ALLOC : KIND_FREE;
            req.size    = $urandom_range(32'(stride), 0);
            req.present = ($urandom_range(49) != 0);
            req.number  = SLOT_W'($urandom_range(usable_slots() - 1));
            if (recycle_top == MAX_SLOTS)
                extra++;
            put_item(req, 1'b0, O_DONE);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("generational_slot_allocator_unit regression: fail");
        $finish;
    end

    initial
    begin : result_side
        int                  hold;
        status_t             got_status;
        logic [SLOT_W-1:0]   got_slot;
        logic [GEN_W-1:0]    got_gen;
        logic [OFFSET_W-1:0] got_offset;
        outcome_t            want;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got_status = status_t'(m_tdata[STATUS_W-1:0]);
                got_slot   = m_tdata[STATUS_W +: SLOT_W];
                got_gen    = m_tdata[STATUS_W + SLOT_W +: GEN_W];
                got_offset = m_tdata[STATUS_W + SLOT_W + GEN_W +: OFFSET_W];
                results_seen++;
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (got_status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 got_status);
                        mismatches++;
                    end
                    if (got_slot !== want.slot)
                    begin
                        $display("%0t: granted_slot expected %0d actual %0d", $time, want.slot,
                                 got_slot);
                        mismatches++;
                    end
                    if (got_gen !== want.gen)
                    begin
                        $display("%0t: granted_generation expected %0d actual %0d", $time,
                                 want.gen, got_gen);
                        mismatches++;
                    end
                    if (got_offset !== want.offset)
                    begin
                        $display("%0t: byte_offset expected %0d actual %0d", $time,
                                 want.offset, got_offset);
                        mismatches++;
                    end
                end
                if (results_seen == 100)
                    hold = 150;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (results_seen >= 400 && results_seen < 650)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        arena_on    = 1'b0;
        stride      = STRIDE_RESET;
        count_reg   = COUNT_RESET;
        reserve0    = 1'b0;
        recycle_top = 0;
        next_fresh  = 0;
        foreach (gen_tbl[i])
        begin
            gen_tbl[i] = 1;
            recycle[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].what == ROW_CFG)
                set_register(plan[r].idx, plan[r].val);
            else
                put_item(plan[r].req, plan[r].typed, plan[r].want);
        end

        set_register(CFG_SLOT_STRIDE, 13'd64);
        set_register(CFG_SLOT_COUNT, 13'd1024);
        run_mix(40, 60);

        set_register(CFG_SLOT_STRIDE, CFG_DATA_W'($urandom_range(4096, 1)));
        set_register(CFG_SLOT_COUNT, CFG_DATA_W'($urandom_range(40, 1)));
        set_register(CFG_RESERVE_FIRST, {CFG_DATA_W{1'b1}});
        run_mix(50, 50);

        set_register(CFG_ARENA_ENABLED, {12'($urandom()), 1'b0});
        run_mix(8, 50);
        set_register(CFG_ARENA_ENABLED, 13'h1FFF);

        set_register(CFG_SLOT_STRIDE, 13'h1FFF);
        set_register(CFG_SLOT_COUNT, 13'd1);
        set_register(CFG_RESERVE_FIRST, 13'd0);
        run_mix(10, 50);
        set_register(CFG_SLOT_COUNT, 13'd1024);
        sender_steady = 1'b1;
        run_mix(40, 55);
        sender_steady = 1'b0;

        set_register(CFG_SLOT_STRIDE, CFG_DATA_W'($urandom_range(4096, 1)));
        fill_recycle_stack(8);
        run_mix(30, 85);

        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("generational_slot_allocator_unit regression: pass");
        else
            $display("generational_slot_allocator_unit regression: fail");
        $finish;
    end

endmodule
